>>> rtl/window_credit_retransmit_sender_defines.svh
// Assertion macros shared by the checker of the retransmit sender.
`ifndef WINDOW_CREDIT_RETRANSMIT_SENDER_DEFINES_SVH
`define WINDOW_CREDIT_RETRANSMIT_SENDER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define WCRS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wcrs same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define WCRS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wcrs next-cycle check failed");

`endif

>>> rtl/wcrs_pkg.sv
// Shared widths, defaults and codes of the retransmit sender.
`default_nettype none
package wcrs_pkg;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int MAX_PAYLOAD_DEF = 512;

  localparam int MODE_W = 2;
  localparam int LEN_W  = 10;
  localparam int WIN_W  = 8;
  localparam int SEQ_W  = 16;
  localparam int KIND_W = 3;

  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPLY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PROBE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EOM    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESEND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STALL  = 3'd4;
endpackage
`default_nettype wire

>>> rtl/wcrs_if.sv
// Event and result channel interfaces of the retransmit sender.
`default_nettype none
interface wcrs_evt_if;
  logic                         valid;
  logic                         ready;
  logic [wcrs_pkg::MODE_W-1:0]  mode;
  logic [wcrs_pkg::LEN_W-1:0]   payload_len;
  logic [wcrs_pkg::WIN_W-1:0]   reply_window;
  logic                         reply_ack_valid;
  logic [wcrs_pkg::SEQ_W-1:0]   reply_ack;

  modport source (output valid, mode, payload_len, reply_window, reply_ack_valid,
                  reply_ack, input ready);
  modport sink (input valid, mode, payload_len, reply_window, reply_ack_valid,
                reply_ack, output ready);
  modport monitor (input valid, ready, mode, payload_len, reply_window,
                   reply_ack_valid, reply_ack);
endinterface

interface wcrs_res_if;
  logic                         valid;
  logic                         ready;
  logic [wcrs_pkg::KIND_W-1:0]  kind;
  logic [wcrs_pkg::SEQ_W-1:0]   segment;
  logic [wcrs_pkg::LEN_W-1:0]   length;
  logic                         last;

  modport source (output valid, kind, segment, length, last, input ready);
  modport sink (input valid, kind, segment, length, last, output ready);
  modport monitor (input valid, ready, kind, segment, length, last);
endinterface
`default_nettype wire

>>> rtl/window_credit_retransmit_sender.sv
// Top level of the credit-windowed go-back-N retransmission sender.
//
//   channel  modport  carries
//   -------  -------  ------------------------------------------------------
//   evt      sink     mode, payload_len, reply_window, reply_ack_valid/ack
//   res      source   kind, segment, length, last (one per send or resend)
//
// An event is taken in IDLE only; the next cycle executes it. A send event
// executes in EXEC and loads the result register there once it is free. A
// reply executes in EXEC and then checks the queue head in POP, popping each
// descriptor the ack covers, until a head check fails or the queue runs
// empty. A timeout executes in EXEC and then resends descriptors in RSND. The
// single descriptor RAM read port (one entry a cycle, in a resend only while
// the result register is free) sets the pop and resend rate. A held result
// stalls the send execute cycle and the resend walk until it is taken;
// reset (synchronous) needs no clearing pass.
`default_nettype none
module window_credit_retransmit_sender #(
  parameter int QUEUE_DEPTH = wcrs_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD = wcrs_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  wcrs_evt_if.sink   evt,
  wcrs_res_if.source res
);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = wcrs_pkg::SEQ_W + wcrs_pkg::LEN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_RSND = 2'd3;

  // Control state
  logic [1:0]                     state;
  logic [CNT_W-1:0]               credit;
  logic [wcrs_pkg::SEQ_W-1:0]     next_seq;
  logic [PTR_W-1:0]               head;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               idx;
  logic                           res_valid;

  // Captured event
  logic [wcrs_pkg::MODE_W-1:0]    item_mode;
  logic [wcrs_pkg::LEN_W-1:0]     item_len;
  logic [wcrs_pkg::WIN_W-1:0]     item_win;
  logic                           item_ack_vld;
  logic [wcrs_pkg::SEQ_W-1:0]     item_ack;

  // Result register
  logic [wcrs_pkg::KIND_W-1:0]    res_kind;
  logic [wcrs_pkg::SEQ_W-1:0]     res_seg;
  logic [wcrs_pkg::LEN_W-1:0]     res_len;
  logic                           res_last;

  // Descriptor RAM: {segment, length} per slot
  logic [ENT_W-1:0]               mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]               rd_data;
  logic [PTR_W-1:0]               rd_addr;
  logic                           wr_en;
  logic [PTR_W-1:0]               wr_addr;
  logic [wcrs_pkg::LEN_W-1:0]     clamp_len;

  logic                           out_free;
  logic                           res_load;
  logic                           pop;
  logic                           rs_last;
  logic [wcrs_pkg::SEQ_W-1:0]     rd_seg;
  logic [wcrs_pkg::LEN_W-1:0]     rd_len;

  // Ring slot at an offset from the head; head + offset stays below twice the depth.
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign evt.ready = (state == ST_IDLE);
  assign res.valid   = res_valid;
  assign res.kind    = res_kind;
  assign res.segment = res_seg;
  assign res.length  = res_len;
  assign res.last    = res_last;

  // The result register can take a new result when empty or being drained.
  assign out_free = !res_valid || res.ready;

  // A send execute cycle or a resend step loads the result register.
  assign res_load = out_free &&
                    (((state == ST_EXEC) && (item_mode == wcrs_pkg::MODE_SEND)) ||
                     (state == ST_RSND));

  assign rd_seg = rd_data[ENT_W-1:wcrs_pkg::LEN_W];
  assign rd_len = rd_data[wcrs_pkg::LEN_W-1:0];

  // Pop while the head descriptor is covered by the cumulative ack.
  assign pop = (count != '0) && (rd_seg <= item_ack);
  // Resend walk ends when credit or the queue runs out.
  assign rs_last = (credit == CNT_W'(1)) || ((idx + CNT_W'(1)) == count);

  // Clamp the payload length to the largest segment.
  assign clamp_len = ({1'b0, item_len} > (wcrs_pkg::LEN_W+1)'(MAX_PAYLOAD)) ?
                     wcrs_pkg::LEN_W'(MAX_PAYLOAD) : item_len;

  assign wr_addr = slot(head, count);
  assign wr_en   = (state == ST_EXEC) && (item_mode == wcrs_pkg::MODE_SEND) &&
                   out_free && (credit != '0) && (item_len != '0) &&
                   (count != CNT_W'(QUEUE_DEPTH));

  // Read address: head on entry, then advance as descriptors are consumed.
  always_comb begin
    case (state)
      ST_POP:  rd_addr = pop ? slot(head, CNT_W'(1)) : head;
      ST_RSND: rd_addr = out_free ? slot(head, idx + CNT_W'(1)) : slot(head, idx);
      default: rd_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {next_seq, clamp_len};
    end
    rd_data <= mem[rd_addr];
  end

  // Capture the event on transfer.
  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      item_mode    <= evt.mode;
      item_len     <= evt.payload_len;
      item_win     <= evt.reply_window;
      item_ack_vld <= evt.reply_ack_valid;
      item_ack     <= evt.reply_ack;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      credit    <= '0;
      next_seq  <= '0;
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once it is taken.
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (evt.valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (item_mode)
            wcrs_pkg::MODE_SEND: begin
              // Hold until the result register is free.
              if (out_free) begin
                res_last  <= 1'b1;
                state     <= ST_IDLE;
                if (credit == '0) begin
                  res_kind <= wcrs_pkg::KIND_PROBE;
                  res_seg  <= '0;
                  res_len  <= '0;
                end else if (item_len == '0) begin
                  res_kind <= wcrs_pkg::KIND_EOM;
                  res_seg  <= '0;
                  res_len  <= '0;
                end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                  res_kind <= wcrs_pkg::KIND_STALL;
                  res_seg  <= '0;
                  res_len  <= '0;
                end else begin
                  res_kind <= wcrs_pkg::KIND_DATA;
                  res_seg  <= next_seq;
                  res_len  <= clamp_len;
                  next_seq <= next_seq + 1'b1;
                  credit   <= credit - 1'b1;
                  count    <= count + 1'b1;
                end
              end
            end
            wcrs_pkg::MODE_REPLY: begin
              // Load credit only from zero, saturated to the ring depth.
              if (item_win != '0 && credit == '0) begin
                credit <= (item_win > wcrs_pkg::WIN_W'(QUEUE_DEPTH)) ?
                          CNT_W'(QUEUE_DEPTH) : CNT_W'(item_win);
              end
              state <= (item_ack_vld && count != '0) ? ST_POP : ST_IDLE;
            end
            wcrs_pkg::MODE_TIMEOUT: begin
              idx   <= '0;
              state <= (credit != '0 && count != '0) ? ST_RSND : ST_IDLE;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_POP: begin
          // One head descriptor checked per cycle.
          if (pop) begin
            head  <= slot(head, CNT_W'(1));
            count <= count - 1'b1;
            if (count == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RSND: begin
          // Resend one descriptor per transfer; the queue itself is kept.
          if (out_free) begin
            res_kind  <= wcrs_pkg::KIND_RESEND;
            res_seg   <= rd_seg;
            res_len   <= rd_len;
            res_last  <= rs_last;
            credit    <= credit - 1'b1;
            idx       <= idx + 1'b1;
            if (rs_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/wcrs_checker.sv
// Port-level checker of the retransmit sender and its bind.
`default_nettype none
`include "window_credit_retransmit_sender_defines.svh"
module wcrs_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        evt_valid,
  input wire logic                        evt_ready,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic [wcrs_pkg::KIND_W-1:0] res_kind,
  input wire logic [wcrs_pkg::SEQ_W-1:0]  res_segment,
  input wire logic [wcrs_pkg::LEN_W-1:0]  res_length,
  input wire logic                        res_last
);
  localparam int WORD_W = wcrs_pkg::KIND_W + wcrs_pkg::SEQ_W + wcrs_pkg::LEN_W + 1;

  logic [WORD_W-1:0] res_word;
  logic              res_mark;

  assign res_word = {res_kind, res_segment, res_length, res_last};
  assign res_mark = (res_kind == wcrs_pkg::KIND_PROBE) || (res_kind == wcrs_pkg::KIND_EOM) ||
                    (res_kind == wcrs_pkg::KIND_STALL);

  `WCRS_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_word))
  `WCRS_ASSERT_NXT(a_one_event, clk, rst, evt_valid && evt_ready, !evt_ready)
  `WCRS_ASSERT_IMP(a_single_last, clk, rst, res_valid && res_kind != wcrs_pkg::KIND_RESEND, res_last)
  `WCRS_ASSERT_IMP(a_mark_empty, clk, rst, res_valid && res_mark, res_segment == '0 && res_length == '0)
endmodule

bind window_credit_retransmit_sender wcrs_checker u_wcrs_checker (
  .clk         (clk),
  .rst         (rst),
  .evt_valid   (evt.valid),
  .evt_ready   (evt.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_kind    (res.kind),
  .res_segment (res.segment),
  .res_length  (res.length),
  .res_last    (res.last)
);
`default_nettype wire
